FILE: design/smss_pkg.sv
`timescale 1ns / 1ps

package smss_pkg;

    // Default sizes handed to the top level
    localparam int DEF_MAX_ROWS    = 16;
    localparam int DEF_MAX_COLS    = 16;
    localparam int DEF_VALUE_WIDTH = 32;

    // Fixed field widths
    localparam int IDX_W     = 4;
    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes and reset value
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b1;
    localparam logic [CFG_W-1:0]     CFG_AREA_RESET = 5'd16;

    // Operation codes
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_CMP,
        ST_DONE
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic write;
        logic step_down;
        logic step_left;
        logic set_hit;
        logic out_load;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic outside;
        logic eq;
        logic lt;
    } t_stat;

endpackage

FILE: design/smss_in_if.sv
`timescale 1ns / 1ps

interface smss_in_if #(
    parameter int VALUE_WIDTH = smss_pkg::DEF_VALUE_WIDTH
) ();
    import smss_pkg::*;

    logic                          valid;
    logic                          ready;
    logic                          operation;
    logic [IDX_W-1:0]              row_index;
    logic [IDX_W-1:0]              col_index;
    logic signed [VALUE_WIDTH-1:0] entry_value;
    logic signed [VALUE_WIDTH-1:0] target;

    modport source (
        output valid, operation, row_index, col_index, entry_value, target,
        input  ready
    );

    modport sink (
        input  valid, operation, row_index, col_index, entry_value, target,
        output ready
    );
endinterface

FILE: design/smss_out_if.sv
`timescale 1ns / 1ps

interface smss_out_if ();
    logic valid;
    logic ready;
    logic found;

    modport source (
        output valid, found,
        input  ready
    );

    modport sink (
        input  valid, found,
        output ready
    );
endinterface

FILE: design/smss_dp.sv
`timescale 1ns / 1ps

module smss_dp #(
    parameter int MAX_ROWS    = smss_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS    = smss_pkg::DEF_MAX_COLS,
    parameter int VALUE_WIDTH = smss_pkg::DEF_VALUE_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [smss_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [smss_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic [smss_pkg::IDX_W-1:0]     i_row_index,
    input  logic [smss_pkg::IDX_W-1:0]     i_col_index,
    input  logic signed [VALUE_WIDTH-1:0]  i_entry_value,
    input  logic signed [VALUE_WIDTH-1:0]  i_target,
    input  smss_pkg::t_cmd                 i_cmd,
    output smss_pkg::t_stat                o_stat,
    output logic                           o_found
);
    import smss_pkg::*;

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RW    = $clog2(MAX_ROWS + 1);
    localparam int CW    = $clog2(MAX_COLS + 1);
    localparam logic [RW-1:0] ROW_LIMIT = RW'(MAX_ROWS);
    localparam logic [CW-1:0] COL_LIMIT = CW'(MAX_COLS);

    logic [CFG_W-1:0]              r_rows_cfg;
    logic [CFG_W-1:0]              r_cols_cfg;
    logic [RW-1:0]                 r_row, n_row;
    logic [CW-1:0]                 r_col, n_col;
    logic signed [VALUE_WIDTH-1:0] r_key;
    logic signed [VALUE_WIDTH-1:0] r_rd_data;
    logic signed [VALUE_WIDTH-1:0] r_mem [DEPTH];
    logic                          r_hit;
    logic                          r_found;

    logic [RW-1:0] nrows;
    logic [CW-1:0] ncols;
    logic          wr_ok;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_cfg <= CFG_AREA_RESET;
            r_cols_cfg <= CFG_AREA_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ROWS: r_rows_cfg <= i_cfg_data;
                CFG_COLS: r_cols_cfg <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Area in use, clamped to the array size
    assign nrows = (int'(r_rows_cfg) > MAX_ROWS) ? ROW_LIMIT : RW'(r_rows_cfg);
    assign ncols = (int'(r_cols_cfg) > MAX_COLS) ? COL_LIMIT : CW'(r_cols_cfg);

    // Addresses: row-major, column pointer is one past the current column
    assign wr_ok   = (int'(i_row_index) < MAX_ROWS) && (int'(i_col_index) < MAX_COLS);
    assign wr_addr = AW'(int'(i_row_index) * MAX_COLS + int'(i_col_index));
    assign rd_addr = AW'(int'(r_row) * MAX_COLS + int'(r_col) - 1);

    // Matrix store, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.write && wr_ok) begin
            r_mem[wr_addr] <= i_entry_value;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // Walk pointers
    always_comb begin
        n_row = r_row;
        n_col = r_col;
        if (i_cmd.load) begin
            n_row = '0;
            n_col = ncols;
        end else if (i_cmd.step_down) begin
            n_row = r_row + RW'(1);
        end else if (i_cmd.step_left) begin
            n_col = r_col - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_row <= n_row;
        r_col <= n_col;
        if (i_cmd.load) begin
            r_key <= i_target;
        end
    end

    // Hit flag and result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_hit <= 1'b0;
        end else if (i_cmd.set_hit) begin
            r_hit <= 1'b1;
        end
        if (i_cmd.out_load) begin
            r_found <= r_hit;
        end
    end

    // Status
    assign o_stat.outside = (r_row >= nrows) || (r_col == '0);
    assign o_stat.eq      = (r_rd_data == r_key);
    assign o_stat.lt      = (r_rd_data < r_key);
    assign o_found        = r_found;

endmodule

FILE: design/smss_ctrl.sv
`timescale 1ns / 1ps

module smss_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    input  logic            i_req_op,
    output logic            o_req_ready,
    input  logic            i_rsp_ready,
    output logic            o_rsp_valid,
    input  smss_pkg::t_stat i_stat,
    output smss_pkg::t_cmd  o_cmd
);
    import smss_pkg::*;

    t_state r_state, n_state;
    logic   r_rsp_valid;
    logic   accept;
    logic   out_free;

    assign o_req_ready = (r_state == ST_IDLE) && i_rst_n;
    assign accept      = i_req_valid && o_req_ready;
    assign out_free    = !r_rsp_valid || i_rsp_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && (i_req_op == OP_SEARCH)) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                n_state = i_stat.outside ? ST_DONE : ST_CMP;
            end
            ST_CMP: begin
                n_state = i_stat.eq ? ST_DONE : ST_CHECK;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        o_cmd = '0;
        case (r_state)
            ST_IDLE: begin
                o_cmd.write = accept && (i_req_op == OP_WRITE);
                o_cmd.load  = accept && (i_req_op == OP_SEARCH);
            end
            ST_CMP: begin
                if (i_stat.eq) begin
                    o_cmd.set_hit = 1'b1;
                end else if (i_stat.lt) begin
                    o_cmd.step_down = 1'b1;
                end else begin
                    o_cmd.step_left = 1'b1;
                end
            end
            ST_DONE: begin
                o_cmd.out_load = out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Result beat valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (o_cmd.out_load) begin
            r_rsp_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    assign o_rsp_valid = r_rsp_valid;

endmodule

FILE: design/sorted_matrix_staircase_search_core.sv
`timescale 1ns / 1ps

// Staircase search over a matrix whose rows and columns ascend.
// i_req carries write and search beats: a write stores entry_value at
// row_index/col_index, a search looks for target in the area set by the
// rows/columns registers (i_cfg_we, i_cfg_idx, i_cfg_data; write while idle).
// o_rsp carries one found beat per search; writes give no beat.
// A write is stored when taken; the next beat is taken in the following cycle.
// A search walks from the top-right corner; for each visited entry it first
// reads the matrix store (ST_CHECK, which also tests for leaving the area),
// then compares (ST_CMP) and steps down when the entry is below target, left
// when above, ending on a match or when it leaves the area; the registered read
// of the matrix store is why each entry needs a read ahead of its compare.
// i_req.ready is low while a search walks. The result sits in an output
// register, so a new beat is taken while it waits; a finished search holds
// until that register is free. Reset (synchronous, active low) clears the
// controller and restores a 16x16 area; matrix contents are not cleared and
// must be written before they are searched.
module sorted_matrix_staircase_search_core #(
    parameter int MAX_ROWS    = smss_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS    = smss_pkg::DEF_MAX_COLS,
    parameter int VALUE_WIDTH = smss_pkg::DEF_VALUE_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [smss_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [smss_pkg::CFG_W-1:0]     i_cfg_data,
    smss_in_if.sink                        i_req,
    smss_out_if.source                     o_rsp
);
    import smss_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    smss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_op    (i_req.operation),
        .o_req_ready (i_req.ready),
        .i_rsp_ready (o_rsp.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    smss_dp #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLS    (MAX_COLS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_row_index   (i_req.row_index),
        .i_col_index   (i_req.col_index),
        .i_entry_value (i_req.entry_value),
        .i_target      (i_req.target),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_found       (o_rsp.found)
    );

endmodule

FILE: design/smss_chk.sv
`timescale 1ns / 1ps

module smss_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_req_valid,
    input logic i_req_ready,
    input logic i_req_op,
    input logic i_rsp_valid,
    input logic i_rsp_ready,
    input logic i_rsp_found
);
    import smss_pkg::*;

    logic wr_beat;
    logic srch_beat;

    assign wr_beat   = i_req_valid && i_req_ready && (i_req_op == OP_WRITE);
    assign srch_beat = i_req_valid && i_req_ready && (i_req_op == OP_SEARCH);

    // After a write the input is ready again in the next cycle
    a_write_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_beat |=> i_req_ready)
        else $error("input not ready after a write beat");

    // A search keeps the input side busy while it walks
    a_search_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        srch_beat |=> !i_req_ready)
        else $error("input ready right after a search beat");

    // No result can appear the cycle after a search starts
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        srch_beat |=> !$rose(i_rsp_valid))
        else $error("result raised before the walk ran");

    // Stalled result beat holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=> (i_rsp_valid && $stable(i_rsp_found)))
        else $error("stalled result beat changed");

endmodule

bind sorted_matrix_staircase_search_core smss_chk u_smss_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_req_op    (i_req.operation),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_found (o_rsp.found)
);
